// ===== hdl/bvll_pkg.sv =====
// bvll_pkg: shared constants, codes and types of the foreign-device link
`default_nettype none

package bvll_pkg;

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned HEAD_W   = 32;
  localparam int unsigned TAIL_W   = 48;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned FN_W     = 8;
  localparam int unsigned OFS_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned COUNT_W  = 26;

  // timer scale
  localparam logic [9:0] TICKS_PER_SECOND = 10'd1000;

  // commands
  localparam logic [CMD_W-1:0] CMD_RX       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TX       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

  // destination kinds
  localparam logic [KIND_W-1:0] DEST_LOCAL = 2'd0;
  localparam logic [KIND_W-1:0] DEST_BCAST = 2'd1;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELIVER  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEND     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEND_REG = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ADDR_ERR = 3'd4;

  // bvlc header codes
  localparam logic [7:0] BVLC_TYPE       = 8'h81;
  localparam logic [FN_W-1:0] FN_RESULT       = 8'h00;
  localparam logic [FN_W-1:0] FN_FORWARDED    = 8'h04;
  localparam logic [FN_W-1:0] FN_REGISTER     = 8'h05;
  localparam logic [FN_W-1:0] FN_DIST_BCAST   = 8'h09;
  localparam logic [FN_W-1:0] FN_ORIG_UNICAST = 8'h0A;
  localparam logic [FN_W-1:0] FN_ORIG_BCAST   = 8'h0B;
  localparam logic [15:0] RESULT_ACK = 16'h0000;
  localparam logic [15:0] RESULT_NAK = 16'h0030;

  // header lengths
  localparam logic [LEN_W-1:0] HDR_LEN     = 16'd4;
  localparam logic [LEN_W-1:0] FWD_HDR_LEN = 16'd10;
  localparam logic [LEN_W-1:0] REG_LEN     = 16'd6;
  localparam logic [OFS_W-1:0] OFS_ORIG    = 4'd4;
  localparam logic [OFS_W-1:0] OFS_FWD     = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BBMD_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BBMD_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL       = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  rx_len;
    logic [HEAD_W-1:0] rx_head;
    logic [TAIL_W-1:0] rx_tail;
    logic [KIND_W-1:0] dest_kind;
    logic [LEN_W-1:0]  tx_payload_len;
  } bvll_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [FN_W-1:0]   bvlc_function;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  ttl_out;
    logic [OFS_W-1:0]  payload_offset;
    logic [LEN_W-1:0]  payload_length;
    logic              has_source;
    logic [TAIL_W-1:0] source_addr;
    logic              registered;
  } bvll_result_t;

  // timer settings handed to the engine
  typedef struct packed {
    logic [LEN_W-1:0]   ttl;
    logic [COUNT_W-1:0] interval;
  } bvll_timer_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/bvll_in_if.sv =====
// bvll_in_if: input item channel
`default_nettype none

interface bvll_in_if import bvll_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [LEN_W-1:0]    rx_len;
  logic [HEAD_W-1:0]   rx_head;
  logic [TAIL_W-1:0]   rx_tail;
  logic [KIND_W-1:0]   dest_kind;
  logic [LEN_W-1:0]    tx_payload_len;

  modport source (output valid, command, rx_len, rx_head, rx_tail, dest_kind,
                  tx_payload_len, input ready);
  modport sink (input valid, command, rx_len, rx_head, rx_tail, dest_kind,
                tx_payload_len, output ready);
endinterface

`default_nettype wire

// ===== hdl/bvll_out_if.sv =====
// bvll_out_if: result item channel
`default_nettype none

interface bvll_out_if import bvll_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [FN_W-1:0]     bvlc_function;
  logic [LEN_W-1:0]    frame_length;
  logic [LEN_W-1:0]    ttl_out;
  logic [OFS_W-1:0]    payload_offset;
  logic [LEN_W-1:0]    payload_length;
  logic                has_source;
  logic [TAIL_W-1:0]   source_addr;
  logic                registered;

  modport source (output valid, action, bvlc_function, frame_length, ttl_out,
                  payload_offset, payload_length, has_source, source_addr,
                  registered, input ready);
  modport sink (input valid, action, bvlc_function, frame_length, ttl_out,
                payload_offset, payload_length, has_source, source_addr,
                registered, output ready);
endinterface

`default_nettype wire

// ===== hdl/bvll_cfg_if.sv =====
// bvll_cfg_if: configuration write channel
`default_nettype none

interface bvll_cfg_if import bvll_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bvll_engine.sv =====
// bvll_engine: registration state, timer and per-item header decisions
`default_nettype none

module bvll_engine import bvll_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire bvll_item_t      item,
  input  wire bvll_timer_cfg_t tcfg,
  output bvll_result_t         result
);

  logic               is_registered;
  logic               is_registered_next;
  logic               timer_running;
  logic               timer_running_next;
  logic [COUNT_W-1:0] ms_countdown;
  logic [COUNT_W-1:0] ms_countdown_next;

  logic [7:0]        rx_type;
  logic [FN_W-1:0]   rx_fn;
  logic [LEN_W-1:0]  rx_mlen;
  logic [15:0]       rx_code;
  logic              hdr_ok;

  // header fields of a received frame
  assign rx_type = item.rx_head[31:24];
  assign rx_fn   = item.rx_head[23:16];
  assign rx_mlen = item.rx_head[15:0];
  assign rx_code = item.rx_tail[47:32];
  assign hdr_ok  = (item.rx_len >= HDR_LEN) && (rx_type == BVLC_TYPE) &&
                   (rx_mlen == item.rx_len);

  // item decode and next state
  always_comb begin
    result             = '0;
    is_registered_next = is_registered;
    timer_running_next = timer_running;
    ms_countdown_next  = ms_countdown;
    unique case (item.command)
      CMD_RX: begin
        if (hdr_ok) begin
          case (rx_fn) inside
            FN_RESULT: begin
              if (rx_code == RESULT_ACK) begin
                is_registered_next = 1'b1;
              end else if (rx_code == RESULT_NAK) begin
                is_registered_next = 1'b0;
                timer_running_next = 1'b0;
              end
            end
            FN_FORWARDED: begin
              if (rx_mlen >= FWD_HDR_LEN) begin
                result.action         = ACT_DELIVER;
                result.bvlc_function  = rx_fn;
                result.frame_length   = rx_mlen;
                result.payload_offset = OFS_FWD;
                result.payload_length = rx_mlen - FWD_HDR_LEN;
                result.has_source     = 1'b1;
                result.source_addr    = item.rx_tail;
              end
            end
            FN_ORIG_UNICAST, FN_ORIG_BCAST: begin
              result.action         = ACT_DELIVER;
              result.bvlc_function  = rx_fn;
              result.frame_length   = rx_mlen;
              result.payload_offset = OFS_ORIG;
              result.payload_length = rx_mlen - HDR_LEN;
            end
            default: begin
            end
          endcase
        end
      end
      CMD_TX: begin
        if (is_registered) begin
          if (item.dest_kind == DEST_LOCAL || item.dest_kind == DEST_BCAST) begin
            result.action        = ACT_SEND;
            result.bvlc_function = (item.dest_kind == DEST_LOCAL) ? FN_ORIG_UNICAST
                                                                  : FN_DIST_BCAST;
            result.frame_length  = item.tx_payload_len + HDR_LEN;
          end else begin
            result.action = ACT_ADDR_ERR;
          end
        end
      end
      CMD_REGISTER: begin
        is_registered_next   = 1'b0;
        timer_running_next   = 1'b1;
        ms_countdown_next    = tcfg.interval;
        result.action        = ACT_SEND_REG;
        result.bvlc_function = FN_REGISTER;
        result.frame_length  = REG_LEN;
        result.ttl_out       = tcfg.ttl;
      end
      CMD_TICK: begin
        if (timer_running) begin
          if (ms_countdown <= COUNT_W'(1)) begin
            ms_countdown_next    = tcfg.interval;
            result.action        = ACT_SEND_REG;
            result.bvlc_function = FN_REGISTER;
            result.frame_length  = REG_LEN;
            result.ttl_out       = tcfg.ttl;
          end else begin
            ms_countdown_next = ms_countdown - COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    result.registered = is_registered_next;
  end

  // state moves only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      is_registered <= 1'b0;
      timer_running <= 1'b0;
      ms_countdown  <= '0;
    end else if (accept) begin
      is_registered <= is_registered_next;
      timer_running <= timer_running_next;
      ms_countdown  <= ms_countdown_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bvll_out_buf.sv =====
// bvll_out_buf: output register with a skid stage behind it
`default_nettype none

module bvll_out_buf import bvll_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire bvll_result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bvll_result_t      out_data
);

  logic         skid_valid;
  bvll_result_t skid_data;
  logic         pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // control: the skid fills only when the output register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || pop) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bvll_foreign_device_link.sv =====
// bvll_foreign_device_link: top level of the bvll foreign-device link layer
//
//   channel   dir   handshake        carries
//   in_ch     in    valid / ready    command, rx_len, rx_head, rx_tail, dest_kind,
//                                    tx_payload_len
//   out_ch    out   valid / ready    action, function, lengths, ttl, source, registered
//   cfg_ch    in    valid / ready    register index, write data (always ready)
//
// one item per cycle while the output buffer has space; each result is registered
// by one pass of decode logic into the output register, or into the skid stage
// a two-entry output buffer keeps input ready high until its skid stage fills
// the ttl interval product is formed when the ttl register is written
// synchronous reset clears registration, timer and all configuration registers
`default_nettype none

module bvll_foreign_device_link import bvll_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  bvll_in_if.sink   in_ch,
  bvll_out_if.source out_ch,
  bvll_cfg_if.sink  cfg_ch
);

  logic [IP_W-1:0]    bbmd_ip;
  logic [PORT_W-1:0]  bbmd_port;
  bvll_timer_cfg_t    tcfg;
  logic               cfg_wr;
  logic               in_accept;
  logic               space;
  bvll_item_t         item;
  bvll_result_t       result;
  bvll_result_t       out_data;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bbmd_ip       <= '0;
      bbmd_port     <= '0;
      tcfg.ttl      <= '0;
      tcfg.interval <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        CFG_BBMD_IP:   bbmd_ip <= cfg_ch.data;
        CFG_BBMD_PORT: bbmd_port <= cfg_ch.data[PORT_W-1:0];
        CFG_TTL: begin
          tcfg.ttl      <= cfg_ch.data[LEN_W-1:0];
          tcfg.interval <= COUNT_W'(cfg_ch.data[LEN_W-1:0] * TICKS_PER_SECOND);
        end
        default: begin
        end
      endcase
    end
  end

  // input beat
  assign in_ch.ready = space;
  assign in_accept   = in_ch.valid && space;

  assign item.command        = in_ch.command;
  assign item.rx_len         = in_ch.rx_len;
  assign item.rx_head        = in_ch.rx_head;
  assign item.rx_tail        = in_ch.rx_tail;
  assign item.dest_kind      = in_ch.dest_kind;
  assign item.tx_payload_len = in_ch.tx_payload_len;

  bvll_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (item),
    .tcfg   (tcfg),
    .result (result)
  );

  bvll_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (result),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // result beat
  assign out_ch.action         = out_data.action;
  assign out_ch.bvlc_function  = out_data.bvlc_function;
  assign out_ch.frame_length   = out_data.frame_length;
  assign out_ch.ttl_out        = out_data.ttl_out;
  assign out_ch.payload_offset = out_data.payload_offset;
  assign out_ch.payload_length = out_data.payload_length;
  assign out_ch.has_source     = out_data.has_source;
  assign out_ch.source_addr    = out_data.source_addr;
  assign out_ch.registered     = out_data.registered;

endmodule

`default_nettype wire

// ===== hdl/bvll_checker.sv =====
// bvll_checker: port-level checks of the foreign-device link, bound to the top level
`default_nettype none

module bvll_checker import bvll_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ACT_W-1:0] action,
  input wire logic [FN_W-1:0]  bvlc_function,
  input wire logic [LEN_W-1:0] frame_length,
  input wire logic [OFS_W-1:0] payload_offset,
  input wire logic             has_source,
  input wire logic             registered
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // registration requests always carry the register header
  a_reg_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_SEND_REG |->
      bvlc_function == FN_REGISTER && frame_length == REG_LEN)
    else $error("malformed registration request");

  // deliveries: source present exactly for the forwarded offset
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_DELIVER |->
      (payload_offset == OFS_FWD && has_source) ||
      (payload_offset == OFS_ORIG && !has_source))
    else $error("delivery offset and source flag disagree");

  // frames and address errors only go out while registered
  a_send_reg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_SEND || action == ACT_ADDR_ERR) |-> registered)
    else $error("send while not registered");

endmodule

bind bvll_foreign_device_link bvll_checker u_bvll_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .action         (out_ch.action),
  .bvlc_function  (out_ch.bvlc_function),
  .frame_length   (out_ch.frame_length),
  .payload_offset (out_ch.payload_offset),
  .has_source     (out_ch.has_source),
  .registered     (out_ch.registered)
);

`default_nettype wire
